[rtl/core/spectral_peak_heart_rate_macros.svh]
// Assertion macros shared by the spectral peak heart-rate block.
// No dependencies; included by the top level only.
`ifndef SPECTRAL_PEAK_HEART_RATE_MACROS_SVH
`define SPECTRAL_PEAK_HEART_RATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPHR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SPHR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sphr_pkg.sv]
// Shared types, constants and helper functions for the heart-rate block.
// No dependencies; used by every module under rtl/core.
package sphr_pkg;

  // Spectrum geometry; the transform length is a power of two.
  localparam int FFT_LOG2   = 9;
  localparam int FFT_SIZE   = 1 << FFT_LOG2;
  localparam int BIN_W      = FFT_LOG2;
  localparam int CNT_W      = 13;
  localparam int PEAK_W     = 12;

  // Field widths.
  localparam int MAG_W      = 32;
  localparam int FREQ_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int SRC_W      = 3;
  localparam int AVG_W      = 3;
  localparam int RATE_W     = 12;
  localparam int BPM_W      = 22;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Divider geometry: numerator is a band edge scaled by the spectrum length,
  // denominator is the effective rate in Q.8.
  localparam int NUM_W      = FREQ_W + FFT_LOG2;
  localparam int DEN_W      = RATE_W + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

  // Heart-rate scaling: 60 BPM per Hz, times 16 for the Q.4 result.
  localparam int BPM_SCALE  = 960;
  localparam int SCALE_W    = 10;
  localparam int PROD_W     = BIN_W + RATE_W;
  localparam int BPM_FULL_W = PROD_W + SCALE_W;

  // Register reset values.
  localparam logic [SRC_W-1:0]      RST_RATE_CODE = SRC_W'(1);
  localparam logic [AVG_W-1:0]      RST_AVG_LOG2  = AVG_W'(0);
  localparam logic [FREQ_W-1:0]     RST_LOW_FREQ  = FREQ_W'(192);
  localparam logic [FREQ_W-1:0]     RST_HIGH_FREQ = FREQ_W'(768);
  localparam logic [MAG_W-1:0]      RST_THRESHOLD = MAG_W'(0);

  localparam logic [CNT_W-1:0]      CNT_MAX       = {CNT_W{1'b1}};
  localparam logic [BIN_W-1:0]      BIN_TOP       = BIN_W'(FFT_SIZE - 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_CODE = 3'd0,
    CFG_AVG_LOG2  = 3'd1,
    CFG_LOW_FREQ  = 3'd2,
    CFG_HIGH_FREQ = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_idx_e;

  // Result status codes; the three error codes are listed in priority order.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_RATE = 2'd1,
    ST_NO_PEAK   = 2'd2,
    ST_LOW_PEAK  = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_DIV_LO,
    CS_DIV_HI,
    CS_MUL,
    CS_EMIT
  } ctrl_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic bin_take;
    logic div_start;
    logic div_hi;
    logic win_lo_ld;
    logic win_hi_ld;
    logic res_calc;
    logic out_ld;
    logic spec_clr;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic first_bin;
    logic rate_zero;
    logic div_done;
    logic out_free;
  } dp_sts_t;

  // Base sample rate for each rate code.
  function automatic logic [RATE_W-1:0] base_rate(logic [SRC_W-1:0] code);
    logic [RATE_W-1:0] r;
    case (code)
      3'd0:    r = RATE_W'(50);
      3'd1:    r = RATE_W'(100);
      3'd2:    r = RATE_W'(200);
      3'd3:    r = RATE_W'(400);
      3'd4:    r = RATE_W'(800);
      3'd5:    r = RATE_W'(1000);
      3'd6:    r = RATE_W'(1600);
      3'd7:    r = RATE_W'(3200);
      default: r = RATE_W'(100);
    endcase
    return r;
  endfunction

  // Effective rate after sample averaging.
  function automatic logic [RATE_W-1:0] eff_rate(logic [SRC_W-1:0] code,
                                                 logic [AVG_W-1:0] avg);
    return base_rate(code) >> avg;
  endfunction

endpackage

[rtl/core/sphr_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on sphr_pkg for operand widths.
module sphr_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sphr_pkg::NUM_W-1:0]  num_i,
  input  logic [sphr_pkg::DEN_W-1:0]  den_i,
  output logic                        done_o,
  output logic [sphr_pkg::NUM_W-1:0]  quo_o,
  output logic                        rem_nz_o
);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [sphr_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [sphr_pkg::NUM_W-1:0]      nq_q, nq_d;
  logic [sphr_pkg::DEN_W-1:0]      rem_q, rem_d;
  logic [sphr_pkg::DEN_W-1:0]      den_q, den_d;
  logic [sphr_pkg::DEN_W:0]        trial;
  logic                            fits;

  // One restoring step: shift in the next numerator bit and try a subtract.
  always_comb begin
    trial = {rem_q, nq_q[sphr_pkg::NUM_W-1]};
    fits  = (trial >= {1'b0, den_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    nq_d   = nq_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = sphr_pkg::DIV_CNT_W'(sphr_pkg::NUM_W);
      nq_d   = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      nq_d  = {nq_q[sphr_pkg::NUM_W-2:0], fits};
      rem_d = fits ? sphr_pkg::DEN_W'(trial - {1'b0, den_q})
                   : trial[sphr_pkg::DEN_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == sphr_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and remainder registers carry no reset.
  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o   = done_q;
  assign quo_o    = nq_q;
  assign rem_nz_o = |rem_q;

endmodule

[rtl/core/sphr_dp.sv]
// Datapath: configuration registers, per-bin peak tracking, window edges,
// result arithmetic and output register. Depends on sphr_pkg and sphr_div.
module sphr_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sphr_pkg::ctrl_cmd_t              cmd_i,
  output sphr_pkg::dp_sts_t                sts_o,
  input  logic                             cfg_we_i,
  input  logic [sphr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sphr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [sphr_pkg::MAG_W-1:0]       bin_magnitude_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [sphr_pkg::STATUS_W-1:0]    status_o,
  output logic [sphr_pkg::PEAK_W-1:0]      peak_bin_o,
  output logic [sphr_pkg::BPM_W-1:0]       rate_bpm_q4_o
);

  // Configuration registers.
  logic [sphr_pkg::SRC_W-1:0]   rate_code_q;
  logic [sphr_pkg::AVG_W-1:0]   avg_log2_q;
  logic [sphr_pkg::FREQ_W-1:0]  low_freq_q;
  logic [sphr_pkg::FREQ_W-1:0]  high_freq_q;
  logic [sphr_pkg::MAG_W-1:0]   threshold_q;

  // Per-spectrum state.
  logic [sphr_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [sphr_pkg::MAG_W-1:0]   prev_q, prev_d;
  logic [sphr_pkg::MAG_W-1:0]   prev2_q, prev2_d;
  logic [sphr_pkg::MAG_W-1:0]   best_q, best_d;
  logic [sphr_pkg::BIN_W-1:0]   best_bin_q, best_bin_d;
  logic                         found_q, found_d;
  logic [sphr_pkg::BIN_W-1:0]   win_lo_q, win_lo_d;
  logic [sphr_pkg::BIN_W-1:0]   win_hi_q, win_hi_d;

  // Upper-edge divider operands latched at bin 0.
  logic [sphr_pkg::NUM_W-1:0]   op_hi_q;
  logic [sphr_pkg::DEN_W-1:0]   op_den_q;

  // Result pipeline.
  sphr_pkg::status_e            res_status_q, res_status_d;
  logic [sphr_pkg::BIN_W-1:0]   res_bin_q;
  logic [sphr_pkg::PROD_W-1:0]  res_prod_q;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic [sphr_pkg::STATUS_W-1:0] out_status_q;
  logic [sphr_pkg::PEAK_W-1:0]  out_bin_q;
  logic [sphr_pkg::BPM_W-1:0]   out_bpm_q;

  logic [sphr_pkg::RATE_W-1:0]     rate;
  logic [sphr_pkg::CNT_W-1:0]      cand;
  logic                            is_peak;
  logic                            div_done;
  logic [sphr_pkg::NUM_W-1:0]      quo;
  logic                            rem_nz;
  logic [sphr_pkg::NUM_W-1:0]      quo_ceil;
  logic [sphr_pkg::BPM_FULL_W-1:0] bpm_full;

  assign rate = sphr_pkg::eff_rate(rate_code_q, avg_log2_q);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_code_q <= sphr_pkg::RST_RATE_CODE;
      avg_log2_q  <= sphr_pkg::RST_AVG_LOG2;
      low_freq_q  <= sphr_pkg::RST_LOW_FREQ;
      high_freq_q <= sphr_pkg::RST_HIGH_FREQ;
      threshold_q <= sphr_pkg::RST_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sphr_pkg::CFG_RATE_CODE: rate_code_q <= cfg_data_i[sphr_pkg::SRC_W-1:0];
        sphr_pkg::CFG_AVG_LOG2:  avg_log2_q  <= cfg_data_i[sphr_pkg::AVG_W-1:0];
        sphr_pkg::CFG_LOW_FREQ:  low_freq_q  <= cfg_data_i[sphr_pkg::FREQ_W-1:0];
        sphr_pkg::CFG_HIGH_FREQ: high_freq_q <= cfg_data_i[sphr_pkg::FREQ_W-1:0];
        sphr_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i[sphr_pkg::MAG_W-1:0];
        default: ;
      endcase
    end
  end

  // Candidate judged one bin late: strictly inside the window and above
  // both neighbours.
  always_comb begin
    cand    = cnt_q - 1'b1;
    is_peak = (cnt_q > sphr_pkg::CNT_W'(1))
              && (cand > sphr_pkg::CNT_W'(win_lo_q))
              && (cand < sphr_pkg::CNT_W'(win_hi_q))
              && (prev_q > bin_magnitude_i)
              && (prev_q > prev2_q);
  end

  // Shared divider for both window edges. The lower edge starts straight
  // from the registers as bin 0 is taken; the upper edge uses the copies
  // latched at that same beat.
  sphr_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .num_i    (cmd_i.div_hi ? op_hi_q : {low_freq_q, {sphr_pkg::FFT_LOG2{1'b0}}}),
    .den_i    (cmd_i.div_hi ? op_den_q : {rate, {sphr_pkg::FRAC_W{1'b0}}}),
    .done_o   (div_done),
    .quo_o    (quo),
    .rem_nz_o (rem_nz)
  );

  assign quo_ceil = quo + sphr_pkg::NUM_W'(rem_nz);

  // Per-bin tracking, window latching and spectrum clear.
  always_comb begin
    cnt_d      = cnt_q;
    prev_d     = prev_q;
    prev2_d    = prev2_q;
    best_d     = best_q;
    best_bin_d = best_bin_q;
    found_d    = found_q;
    win_lo_d   = win_lo_q;
    win_hi_d   = win_hi_q;
    if (cmd_i.bin_take) begin
      if (cnt_q == '0) begin
        if (rate == '0) begin
          win_lo_d = '0;
          win_hi_d = '0;
        end
      end else if (is_peak && (!found_q || prev_q > best_q)) begin
        best_d     = prev_q;
        best_bin_d = cand[sphr_pkg::BIN_W-1:0];
        found_d    = 1'b1;
      end
      prev2_d = prev_q;
      prev_d  = bin_magnitude_i;
      if (cnt_q != sphr_pkg::CNT_MAX) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
    if (cmd_i.win_lo_ld) begin
      win_lo_d = (quo > sphr_pkg::NUM_W'(sphr_pkg::BIN_TOP))
                 ? sphr_pkg::BIN_TOP : quo[sphr_pkg::BIN_W-1:0];
    end
    if (cmd_i.win_hi_ld) begin
      win_hi_d = (quo_ceil > sphr_pkg::NUM_W'(sphr_pkg::BIN_TOP))
                 ? sphr_pkg::BIN_TOP : quo_ceil[sphr_pkg::BIN_W-1:0];
    end
    if (cmd_i.spec_clr) begin
      cnt_d      = '0;
      prev_d     = '0;
      prev2_d    = '0;
      best_d     = '0;
      best_bin_d = '0;
      found_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      prev_q     <= '0;
      prev2_q    <= '0;
      best_q     <= '0;
      best_bin_q <= '0;
      found_q    <= 1'b0;
      win_lo_q   <= '0;
      win_hi_q   <= '0;
    end else begin
      cnt_q      <= cnt_d;
      prev_q     <= prev_d;
      prev2_q    <= prev2_d;
      best_q     <= best_d;
      best_bin_q <= best_bin_d;
      found_q    <= found_d;
      win_lo_q   <= win_lo_d;
      win_hi_q   <= win_hi_d;
    end
  end

  // Upper-edge operands captured with bin 0 so later register writes cannot
  // disturb the second division.
  always_ff @(posedge clk_i) begin
    if (cmd_i.bin_take && cnt_q == '0) begin
      op_hi_q  <= {high_freq_q, {sphr_pkg::FFT_LOG2{1'b0}}};
      op_den_q <= {rate, {sphr_pkg::FRAC_W{1'b0}}};
    end
  end

  // Status by priority: zero rate, no peak, peak not above threshold.
  always_comb begin
    if (rate == '0) begin
      res_status_d = sphr_pkg::ST_ZERO_RATE;
    end else if (!found_q) begin
      res_status_d = sphr_pkg::ST_NO_PEAK;
    end else if (best_q <= threshold_q) begin
      res_status_d = sphr_pkg::ST_LOW_PEAK;
    end else begin
      res_status_d = sphr_pkg::ST_OK;
    end
  end

  // First product: peak bin times effective rate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_calc) begin
      res_status_q <= res_status_d;
      res_bin_q    <= found_q ? best_bin_q : '0;
      res_prod_q   <= sphr_pkg::PROD_W'(best_bin_q) * sphr_pkg::PROD_W'(rate);
    end
  end

  // Second product scales to 1/16 BPM; dividing by the spectrum length is
  // a plain right shift.
  assign bpm_full = sphr_pkg::BPM_FULL_W'(res_prod_q)
                    * sphr_pkg::BPM_FULL_W'(sphr_pkg::BPM_SCALE);

  // Output register and its valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_status_q <= '0;
      out_bin_q    <= '0;
      out_bpm_q    <= '0;
    end else if (cmd_i.out_ld) begin
      out_status_q <= res_status_q;
      out_bin_q    <= sphr_pkg::PEAK_W'(res_bin_q);
      out_bpm_q    <= (res_status_q == sphr_pkg::ST_OK)
                      ? sphr_pkg::BPM_W'(bpm_full >> sphr_pkg::FFT_LOG2) : '0;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts_o.first_bin = (cnt_q == '0);
    sts_o.rate_zero = (rate == '0);
    sts_o.div_done  = div_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign peak_bin_o    = out_bin_q;
  assign rate_bpm_q4_o = out_bpm_q;

endmodule

[rtl/core/sphr_ctrl.sv]
// Controller state machine: sequences bin intake, the window divisions,
// the result arithmetic and the output load. Depends on sphr_pkg.
module sphr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  output sphr_pkg::ctrl_cmd_t  cmd_o,
  input  sphr_pkg::dp_sts_t    sts_i
);

  sphr_pkg::ctrl_state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sphr_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          if (in_last_i) begin
            state_d = sphr_pkg::CS_MUL;
          end else if (sts_i.first_bin && !sts_i.rate_zero) begin
            state_d = sphr_pkg::CS_DIV_LO;
          end
        end
      end
      sphr_pkg::CS_DIV_LO: begin
        if (sts_i.div_done) begin
          state_d = sphr_pkg::CS_DIV_HI;
        end
      end
      sphr_pkg::CS_DIV_HI: begin
        if (sts_i.div_done) begin
          state_d = sphr_pkg::CS_IDLE;
        end
      end
      sphr_pkg::CS_MUL: begin
        state_d = sphr_pkg::CS_EMIT;
      end
      sphr_pkg::CS_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sphr_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = sphr_pkg::CS_IDLE;
      end
    endcase
  end

  // Output decode.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sphr_pkg::CS_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.bin_take = in_valid_i;
        cmd_o.div_start = in_valid_i && !in_last_i && sts_i.first_bin
                          && !sts_i.rate_zero;
      end
      sphr_pkg::CS_DIV_LO: begin
        cmd_o.win_lo_ld = sts_i.div_done;
        cmd_o.div_start = sts_i.div_done;
        cmd_o.div_hi    = 1'b1;
      end
      sphr_pkg::CS_DIV_HI: begin
        cmd_o.win_hi_ld = sts_i.div_done;
      end
      sphr_pkg::CS_MUL: begin
        cmd_o.res_calc = 1'b1;
      end
      sphr_pkg::CS_EMIT: begin
        cmd_o.out_ld   = sts_i.out_free;
        cmd_o.spec_clr = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sphr_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/core/spectral_peak_heart_rate.sv]
// Top level of the spectral peak heart-rate estimator.
// Depends on sphr_pkg, sphr_ctrl, sphr_dp and the assertion macro header.
//
//   Channel  Direction  Handshake                 Beat contents
//   in       input      in_valid_i / in_ready_o    bin_magnitude_i, last_bin_i
//   out      output     out_valid_o / out_ready_i  status_o, peak_bin_o, rate_bpm_q4_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A bin other than bin 0 or the last bin is taken without leaving the idle state.
// Bin 0, unless it is also the last bin or the effective rate is zero, runs the
// shared restoring divider twice for the window edges, one quotient bit a cycle.
// The last bin is followed by the first product, then the second product into
// the output register, which waits for the previous result to leave.
// Reset is asynchronous and needs no clearing pass; cfg_ready_o is always high.
`include "spectral_peak_heart_rate_macros.svh"

module spectral_peak_heart_rate (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sphr_pkg::MAG_W-1:0]       bin_magnitude_i,
  input  logic                             last_bin_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sphr_pkg::STATUS_W-1:0]    status_o,
  output logic [sphr_pkg::PEAK_W-1:0]      peak_bin_o,
  output logic [sphr_pkg::BPM_W-1:0]       rate_bpm_q4_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sphr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sphr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  sphr_pkg::ctrl_cmd_t cmd;
  sphr_pkg::dp_sts_t   sts;

  // Register writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  sphr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (last_bin_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Arithmetic and storage.
  sphr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .bin_magnitude_i (bin_magnitude_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .peak_bin_o      (peak_bin_o),
    .rate_bpm_q4_o   (rate_bpm_q4_o)
  );

  // A last-bin beat always stalls the input while the result is formed.
  `SPHR_ASSERT_NEXT(a_last_stalls, clk_i, rst_ni, in_valid_i && in_ready_o && last_bin_i, !in_ready_o, "input not stalled after last bin")
  // Only a good status carries a heart rate.
  `SPHR_ASSERT_NOW(a_bpm_only_ok, clk_i, rst_ni, out_valid_o && (status_o != sphr_pkg::ST_OK), rate_bpm_q4_o == '0, "heart rate reported with bad status")
  // No peak found means peak bin zero.
  `SPHR_ASSERT_NOW(a_no_peak_bin, clk_i, rst_ni, out_valid_o && (status_o == sphr_pkg::ST_NO_PEAK), peak_bin_o == '0, "peak bin set without a peak")

endmodule

[tb/spectral_peak_heart_rate_tb.sv]
// Self-checking testbench for the spectral peak heart-rate estimator.
// Depends on sphr_pkg and spectral_peak_heart_rate; a directed table runs first,
// then random spectra under several register settings and idling patterns.
module spectral_peak_heart_rate_tb;
  import sphr_pkg::*;

  localparam longint unsigned BINS = FFT_SIZE;
  localparam int SETTLE_CYCLES = 80;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 138;

  typedef struct packed {
    status_e           status;
    logic [PEAK_W-1:0] peak_bin;
    logic [BPM_W-1:0]  rate_bpm;
  } reading_t;

  // One row of the directed table: a register write or a spectrum bin.
  typedef struct {
    bit        is_reg;
    cfg_idx_e  idx;
    logic [31:0] value;
    bit        last;
    bit        typed;
    reading_t  reading;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [MAG_W-1:0]      bin_magnitude_i = '0;
  logic                  last_bin_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [PEAK_W-1:0]     peak_bin_o;
  logic [BPM_W-1:0]      rate_bpm_q4_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Register copies kept by the predictor.
  logic [2:0]  sel_rate_code;
  logic [2:0]  sel_avg_log2;
  logic [15:0] band_low_q8;
  logic [15:0] band_high_q8;
  logic [31:0] min_peak;

  // Per-spectrum state kept by the predictor.
  logic [12:0] bins_seen;
  logic [31:0] mag_d1;
  logic [31:0] mag_d2;
  logic [12:0] edge_low;
  logic [12:0] edge_high;
  logic [31:0] top_mag;
  logic [11:0] top_bin;
  bit          top_valid;

  reading_t    pending_readings[$];
  stim_row_t   directed_rows[$];
  int          mismatches = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          spec_left = 0;
  int          spec_mode = 0;

  spectral_peak_heart_rate dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .bin_magnitude_i(bin_magnitude_i),
    .last_bin_i     (last_bin_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .peak_bin_o     (peak_bin_o),
    .rate_bpm_q4_o  (rate_bpm_q4_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Samples per second after averaging.
  function automatic longint unsigned samples_per_s(logic [2:0] code, logic [2:0] shift);
    longint unsigned base;
    case (code)
      3'd0: base = 50;
      3'd1: base = 100;
      3'd2: base = 200;
      3'd3: base = 400;
      3'd4: base = 800;
      3'd5: base = 1000;
      3'd6: base = 1600;
      default: base = 3200;
    endcase
    return base >> shift;
  endfunction

  function automatic logic [12:0] clamp_edge(longint unsigned v);
    return (v > BINS - 1) ? 13'(BINS - 1) : 13'(v);
  endfunction

  // Advances the spectrum state by one bin; a last bin yields a reading.
  function automatic void track_bin(input logic [31:0] mag, input bit last,
                                    output bit got, output reading_t rd);
    longint unsigned r;
    longint unsigned d;
    logic [12:0] cand;
    got = 1'b0;
    rd = '0;
    if (bins_seen == 0) begin
      // The window is latched from the registers as they stand at bin 0.
      r = samples_per_s(sel_rate_code, sel_avg_log2);
      if (r == 0) begin
        edge_low = '0;
        edge_high = '0;
      end else begin
        d = r * 256;
        edge_low = clamp_edge((64'(band_low_q8) * BINS) / d);
        edge_high = clamp_edge((64'(band_high_q8) * BINS + d - 1) / d);
      end
    end else if (bins_seen >= 2) begin
      // The previous bin is judged now that its successor is known.
      cand = bins_seen - 13'd1;
      if (cand > edge_low && cand < edge_high && mag_d1 > mag && mag_d1 > mag_d2) begin
        if (!top_valid || mag_d1 > top_mag) begin
          top_mag = mag_d1;
          top_bin = cand[11:0];
          top_valid = 1'b1;
        end
      end
    end
    mag_d2 = mag_d1;
    mag_d1 = mag;
    if (bins_seen != CNT_MAX) bins_seen = bins_seen + 13'd1;
    if (last) begin
      r = samples_per_s(sel_rate_code, sel_avg_log2);
      got = 1'b1;
      if (r == 0) rd.status = ST_ZERO_RATE;
      else if (!top_valid) rd.status = ST_NO_PEAK;
      else if (top_mag <= min_peak) rd.status = ST_LOW_PEAK;
      else begin
        rd.status = ST_OK;
        rd.rate_bpm = BPM_W'((64'd960 * 64'(top_bin) * r) / BINS);
      end
      rd.peak_bin = top_valid ? top_bin : '0;
      bins_seen = '0;
      mag_d1 = '0;
      mag_d2 = '0;
      top_mag = '0;
      top_bin = '0;
      top_valid = 1'b0;
    end
  endfunction

  // Sends one bin; the reading it causes, if any, is queued.
  task automatic push_bin(logic [31:0] mag, bit last, bit typed, reading_t typed_rd);
    bit got;
    reading_t rd;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    bin_magnitude_i <= mag;
    last_bin_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    track_bin(mag, last, got, rd);
    if (got) begin
      pending_readings.push_back(typed ? typed_rd : rd);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RATE_CODE: sel_rate_code = value[2:0];
      CFG_AVG_LOG2:  sel_avg_log2 = value[2:0];
      CFG_LOW_FREQ:  band_low_q8 = value[15:0];
      CFG_HIGH_FREQ: band_high_q8 = value[15:0];
      CFG_THRESHOLD: min_peak = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every reading has left and the block has had time to go idle.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic void add_bin(logic [31:0] mag, bit last);
    stim_row_t row;
    row = '{is_reg: 1'b0, idx: CFG_RATE_CODE, value: mag, last: last,
            typed: 1'b0, reading: '0};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_reg(cfg_idx_e idx, logic [31:0] value);
    stim_row_t row;
    row = '{is_reg: 1'b1, idx: idx, value: value, last: 1'b0,
            typed: 1'b0, reading: '0};
    directed_rows.push_back(row);
  endfunction

  // Attaches a hand-written reading to the most recent row.
  function automatic void add_reading(status_e st, logic [PEAK_W-1:0] pk,
                                      logic [BPM_W-1:0] bpm);
    directed_rows[directed_rows.size()-1].typed = 1'b1;
    directed_rows[directed_rows.size()-1].reading = '{status: st, peak_bin: pk, rate_bpm: bpm};
  endfunction

  function automatic logic [31:0] draw_magnitude(int mode);
    logic [31:0] m;
    case (mode)
      0: m = $urandom_range(0, 15);
      1: m = $urandom();
      default: begin
        case ($urandom_range(0, 2))
          0: m = '0;
          1: m = 32'hFFFF_FFFF;
          default: m = 32'h8000_0000;
        endcase
      end
    endcase
    return m;
  endfunction

  // Sends a number of bins; spectra carry on across calls and register changes.
  task automatic run_items(int quota);
    int n;
    int k;
    for (n = 0; n < quota; n++) begin
      if (spec_left == 0) begin
        k = $urandom_range(0, 99);
        if (k < 90) spec_left = $urandom_range(1, 40);
        else if (k < 98) spec_left = $urandom_range(41, 100);
        else spec_left = $urandom_range(500, 620);
        k = $urandom_range(0, 9);
        spec_mode = (k < 6) ? 0 : (k < 8) ? 1 : 2;
      end
      spec_left--;
      push_bin(draw_magnitude(spec_mode), spec_left == 0, 1'b0, '0);
    end
  endtask

  // Register setting for one phase: fixed extremes first, then random bands.
  task automatic program_setting(int p);
    logic [2:0]  code;
    logic [2:0]  avg;
    logic [15:0] lo_q8;
    logic [15:0] hi_q8;
    logic [31:0] thr;
    longint unsigned r;
    longint unsigned v;
    int lo_b;
    case (p)
      0: begin code = 3'd1; avg = 3'd0; lo_q8 = 16'd192; hi_q8 = 16'd768; thr = '0; end
      1: begin code = 3'd0; avg = 3'd0; lo_q8 = '0; hi_q8 = '0; thr = '0; end
      2: begin code = 3'd7; avg = 3'd7; lo_q8 = '1; hi_q8 = '1; thr = '1; end
      3: begin code = 3'd7; avg = 3'd0; lo_q8 = '0; hi_q8 = '1; thr = '0; end
      default: begin
        code = 3'($urandom_range(0, 7));
        avg = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                          : 3'($urandom_range(0, 2));
        r = samples_per_s(code, avg);
        // A band edge of bin b sits near b * rate / 2 in Q8.8 Hz.
        lo_b = $urandom_range(0, 20);
        v = lo_b * r / 2 + $urandom_range(0, int'(r / 2));
        lo_q8 = (v > 65535) ? 16'hFFFF : 16'(v);
        v = (lo_b + $urandom_range(0, 30)) * r / 2 + $urandom_range(0, int'(r / 2));
        hi_q8 = (v > 65535) ? 16'hFFFF : 16'(v);
        if ($urandom_range(0, 4) == 0) lo_q8 = 16'($urandom());
        if ($urandom_range(0, 4) == 0) hi_q8 = 16'($urandom());
        case ($urandom_range(0, 3))
          0: thr = '0;
          1: thr = $urandom();
          default: thr = $urandom_range(0, 15);
        endcase
      end
    endcase
    write_reg(CFG_RATE_CODE, {29'($urandom()), code});
    write_reg(CFG_AVG_LOG2, {29'($urandom()), avg});
    write_reg(CFG_LOW_FREQ, {16'($urandom()), lo_q8});
    write_reg(CFG_HIGH_FREQ, {16'($urandom()), hi_q8});
    write_reg(CFG_THRESHOLD, thr);
  endtask

  // The receiver drops ready at random, as the phase asks.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Every reading beat is compared with the oldest prediction.
  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readings.size() == 0) begin
        $error("reading beat with none expected: status %0d peak_bin %0d rate_bpm_q4 %0d",
               status_o, peak_bin_o, rate_bpm_q4_o);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (peak_bin_o !== want.peak_bin) begin
          $error("peak_bin: expected %0d, got %0d", want.peak_bin, peak_bin_o);
          mismatches++;
        end
        if (rate_bpm_q4_o !== want.rate_bpm) begin
          $error("rate_bpm_q4: expected %0d, got %0d", want.rate_bpm, rate_bpm_q4_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(24_000_000);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int i;
    int p;
    sel_rate_code = 3'd1;
    sel_avg_log2 = 3'd0;
    band_low_q8 = 16'd192;
    band_high_q8 = 16'd768;
    min_peak = '0;
    bins_seen = '0;
    mag_d1 = '0;
    mag_d2 = '0;
    edge_low = '0;
    edge_high = '0;
    top_mag = '0;
    top_bin = '0;
    top_valid = 1'b0;

    // After reset a single bin cannot be a peak.
    add_bin(32'd0, 1'b1);
    add_reading(ST_NO_PEAK, '0, '0);
    // Two equal full-scale peaks inside the reset window; the earlier one wins.
    for (i = 0; i < 8; i++) add_bin((i == 4 || i == 6) ? 32'hFFFF_FFFF : 32'd0, i == 7);
    // The same spectrum against the largest threshold.
    add_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
    for (i = 0; i < 8; i++) add_bin((i == 4 || i == 6) ? 32'hFFFF_FFFF : 32'd0, i == 7);
    add_reading(ST_LOW_PEAK, 12'd4, '0);
    // Averaging shifts the slowest rate down to zero.
    add_reg(CFG_THRESHOLD, 32'd0);
    add_reg(CFG_RATE_CODE, 32'd0);
    add_reg(CFG_AVG_LOG2, 32'd7);
    add_bin(32'hFFFF_FFFF, 1'b1);
    add_reading(ST_ZERO_RATE, '0, '0);
    // Rate falls to zero mid-spectrum: the latched window still finds the peak.
    add_reg(CFG_RATE_CODE, 32'd1);
    add_reg(CFG_AVG_LOG2, 32'd0);
    add_bin(32'd0, 1'b0);
    add_bin(32'd5, 1'b0);
    add_bin(32'd6, 1'b0);
    add_bin(32'd7, 1'b0);
    add_bin(32'd9, 1'b0);
    add_bin(32'd2, 1'b0);
    add_reg(CFG_RATE_CODE, 32'd0);
    add_reg(CFG_AVG_LOG2, 32'd7);
    add_bin(32'd3, 1'b1);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        settle();
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        push_bin(directed_rows[i].value, directed_rows[i].last,
                 directed_rows[i].typed, directed_rows[i].reading);
      end
    end

    // Random phases, each with its own registers and idling pattern.
    for (p = 0; p < PHASES; p++) begin
      settle();
      program_setting(p);
      case (p % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 46; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 46; end
        default: begin send_idle = 20; recv_idle = 20; end
      endcase
      run_items(PHASE_ITEMS);
    end
    if (spec_left != 0) run_items(spec_left);

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/sphr_pkg.sv
rtl/core/sphr_div.sv
rtl/core/sphr_dp.sv
rtl/core/sphr_ctrl.sv
rtl/core/spectral_peak_heart_rate.sv
tb/spectral_peak_heart_rate_tb.sv
